// ===== src/haptic_client_level_mixer_assert.svh =====
// Assertion macros for the haptic client level mixer.
// Uses clk and rst_n of the including module; needs no other file.
`ifndef HAPTIC_CLIENT_LEVEL_MIXER_ASSERT_SVH
`define HAPTIC_CLIENT_LEVEL_MIXER_ASSERT_SVH

// same-cycle implication
`define HCLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HCLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/hclm_pkg.sv =====
// Shared types and constants of the haptic client level mixer.
// Used by hclm_cell and haptic_client_level_mixer; depends on nothing.
package hclm_pkg;

  localparam int MAX_CLIENTS = 16;
  localparam int LEVEL_BITS  = 8;
  localparam int HANDLE_W    = 16;
  localparam int SUM_W       = 12;
  localparam int DUR_W       = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [2:0] MODE_OPEN    = 3'd0;
  localparam logic [2:0] MODE_CLOSE   = 3'd1;
  localparam logic [2:0] MODE_PLAY    = 3'd2;
  localparam logic [2:0] MODE_ONESHOT = 3'd3;
  localparam logic [2:0] MODE_STOP    = 3'd4;
  localparam logic [2:0] MODE_LEVEL   = 3'd5;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOTFOUND = 2'd1;
  localparam logic [1:0] STAT_FULL     = 2'd2;
  localparam logic [1:0] STAT_INVALID  = 2'd3;

  typedef struct packed {
    logic [2:0]            mode;
    logic [HANDLE_W-1:0]   handle;
    logic [LEVEL_BITS-1:0] level;
  } cmd_t;

  typedef struct packed {
    logic                  valid;
    logic [HANDLE_W-1:0]   handle;
    logic [LEVEL_BITS-1:0] level;
    logic                  playing;
  } entry_t;

  typedef struct packed {
    logic             active;
    logic             hit;
    logic             shift;
    logic             any_play;
    logic [SUM_W-1:0] sum;
  } tok_t;

endpackage

// ===== src/hclm_cell.sv =====
// One table entry of the haptic client level mixer chain.
// Updates its entry when the scan token passes and hands the token on.
// Depends on hclm_pkg.
module hclm_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  hclm_pkg::cmd_t   cmd,
  input  hclm_pkg::tok_t   tok_in,
  input  hclm_pkg::entry_t nbr_in,
  output hclm_pkg::entry_t ent_out,
  output hclm_pkg::tok_t   tok_out
);

  logic                            valid_r;
  logic [hclm_pkg::HANDLE_W-1:0]   handle_r;
  logic [hclm_pkg::LEVEL_BITS-1:0] level_r;
  logic                            playing_r;
  hclm_pkg::tok_t                  tok_r;

  hclm_pkg::entry_t ent_nxt;
  hclm_pkg::tok_t   tok_nxt;
  logic             match;
  logic [hclm_pkg::SUM_W:0] sum_add;

  assign ent_out = '{valid: valid_r, handle: handle_r, level: level_r, playing: playing_r};
  assign tok_out = tok_r;

  assign match = tok_in.active && valid_r && (handle_r == cmd.handle) && !tok_in.hit;

  always_comb begin
    ent_nxt = ent_out;
    tok_nxt = tok_in;
    sum_add = '0;
    if (tok_in.shift) begin
      ent_nxt = nbr_in;
    end else begin
      case (cmd.mode)
        hclm_pkg::MODE_OPEN: begin
          if (!valid_r && !tok_in.hit) begin
            ent_nxt = '{valid: 1'b1, handle: cmd.handle, level: '0, playing: 1'b0};
            tok_nxt.hit = 1'b1;
          end
        end
        hclm_pkg::MODE_CLOSE: begin
          if (match) begin
            tok_nxt.hit   = 1'b1;
            tok_nxt.shift = 1'b1;
            ent_nxt       = nbr_in;
          end
        end
        hclm_pkg::MODE_PLAY: begin
          if (match) begin
            tok_nxt.hit     = 1'b1;
            ent_nxt.level   = '0;
            ent_nxt.playing = 1'b1;
          end
        end
        hclm_pkg::MODE_STOP: begin
          if (match) begin
            tok_nxt.hit     = 1'b1;
            ent_nxt.level   = '0;
            ent_nxt.playing = 1'b0;
          end
        end
        hclm_pkg::MODE_LEVEL: begin
          if (match) begin
            tok_nxt.hit   = 1'b1;
            ent_nxt.level = cmd.level;
          end
        end
        hclm_pkg::MODE_ONESHOT: begin
          if (match) begin
            tok_nxt.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (ent_nxt.valid && ent_nxt.playing) begin
      tok_nxt.any_play = 1'b1;
      sum_add = {1'b0, tok_in.sum} + (hclm_pkg::SUM_W+1)'(ent_nxt.level);
      tok_nxt.sum = sum_add[hclm_pkg::SUM_W] ? hclm_pkg::SUM_MAX
                                             : sum_add[hclm_pkg::SUM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    tok_r.hit      <= tok_nxt.hit;
    tok_r.shift    <= tok_nxt.shift;
    tok_r.any_play <= tok_nxt.any_play;
    tok_r.sum      <= tok_nxt.sum;
    if (!rst_n) begin
      valid_r      <= 1'b0;
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_in.active;
      if (tok_in.active) begin
        valid_r <= ent_nxt.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.active) begin
      handle_r  <= ent_nxt.handle;
      level_r   <= ent_nxt.level;
      playing_r <= ent_nxt.playing;
    end
  end

endmodule

// ===== src/haptic_client_level_mixer.sv =====
// Haptic client level mixer: an accepted item sends a scan token through the 16-cell
// chain, one cell a cycle, and the result is registered at the output. New items are
// taken only in idle; a result may wait at the output while the next item is taken.
// Reset (rst_n low, synchronous) clears the table and the handshake state.
// Depends on hclm_pkg, hclm_cell and haptic_client_level_mixer_assert.svh.
`include "haptic_client_level_mixer_assert.svh"

module haptic_client_level_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,   // mode[2:0]
  input  logic [39:0] in_tdata,   // client_handle[15:0], level_in[23:16], duration_in[39:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], enable_write[2], enable_value[3],
                                  // level_write[4], level_out[16:5], oneshot_write[17],
                                  // oneshot_duration[33:18], zero[39:34]
);

  localparam int N = hclm_pkg::MAX_CLIENTS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  hclm_pkg::cmd_t             cmd_r;
  logic [hclm_pkg::DUR_W-1:0] dur_r;
  hclm_pkg::tok_t             start_r;
  hclm_pkg::tok_t             fin_r;
  logic                       out_valid_r;
  logic [39:0]                out_data_r;

  hclm_pkg::tok_t   tok [N+1];
  hclm_pkg::entry_t ent [N];
  logic [N:0]       tok_act;
  logic [N-1:0]     vld_vec;

  logic        in_acc;
  logic        out_free;
  logic [1:0]  status;
  logic        en_w, en_v, lv_w, os_w;
  logic [hclm_pkg::SUM_W-1:0] lv_o;
  logic [hclm_pkg::DUR_W-1:0] os_d;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  assign tok[0] = start_r;

  for (genvar i = 0; i < N; i++) begin : g_cell
    hclm_pkg::entry_t nbr;
    if (i == N - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    hclm_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_r),
      .tok_in  (tok[i]),
      .nbr_in  (nbr),
      .ent_out (ent[i]),
      .tok_out (tok[i+1])
    );
    assign vld_vec[i] = ent[i].valid;
  end

  for (genvar j = 0; j <= N; j++) begin : g_act
    assign tok_act[j] = tok[j].active;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN: if (tok[N].active) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    status = hclm_pkg::STAT_OK;
    en_w   = 1'b0;
    en_v   = 1'b0;
    lv_w   = 1'b0;
    lv_o   = '0;
    os_w   = 1'b0;
    os_d   = '0;
    unique case (cmd_r.mode) inside
      hclm_pkg::MODE_OPEN: begin
        if (!fin_r.hit) status = hclm_pkg::STAT_FULL;
      end
      hclm_pkg::MODE_CLOSE, hclm_pkg::MODE_STOP: begin
        if (!fin_r.hit) begin
          status = hclm_pkg::STAT_NOTFOUND;
        end else if (!fin_r.any_play) begin
          en_w = 1'b1;
        end
      end
      hclm_pkg::MODE_PLAY: begin
        if (!fin_r.hit) begin
          status = hclm_pkg::STAT_NOTFOUND;
        end else begin
          en_w = 1'b1;
          en_v = 1'b1;
        end
      end
      hclm_pkg::MODE_ONESHOT: begin
        if (fin_r.hit) begin
          lv_w = 1'b1;
          lv_o = hclm_pkg::SUM_W'(cmd_r.level);
          os_w = 1'b1;
          os_d = dur_r;
        end
      end
      hclm_pkg::MODE_LEVEL: begin
        if (!fin_r.hit) begin
          status = hclm_pkg::STAT_NOTFOUND;
        end else begin
          lv_w = 1'b1;
          lv_o = fin_r.sum;
        end
      end
      default: status = hclm_pkg::STAT_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    start_r.hit      <= 1'b0;
    start_r.shift    <= 1'b0;
    start_r.any_play <= 1'b0;
    start_r.sum      <= '0;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      start_r.active <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      start_r.active <= in_acc;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r.mode   <= in_tuser;
      cmd_r.handle <= in_tdata[15:0];
      cmd_r.level  <= in_tdata[16 +: hclm_pkg::LEVEL_BITS];
      dur_r        <= in_tdata[39:24];
    end
    if (tok[N].active) begin
      fin_r <= tok[N];
    end
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {6'd0, os_d, os_w, lv_o, lv_w, en_v, en_w, status};
    end
  end

  `HCLM_ASSERT_IMP(a_tok_single, 1'b1, $onehot0(tok_act), "more than one scan token in chain")
  `HCLM_ASSERT_NXT(a_tok_launch, in_acc, tok_act[0], "accepted item did not launch a token")
  `HCLM_ASSERT_IMP(a_tok_end, tok_act[N], state_r == ST_SCAN, "token left chain outside scan")
  `HCLM_ASSERT_IMP(a_tbl_packed, state_r == ST_IDLE, (vld_vec & (vld_vec + N'(1))) == '0,
    "valid entries not packed from cell zero")

endmodule
